@@ rtl/assert_macros.svh @@
// Assertion helpers for the RTL files; bsi_back includes them.
// BSI_ASSERT checks a condition at every clock edge out of reset.
// BSI_ASSERT_IMP checks an implication at every clock edge out of reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define BSI_ASSERT(name, clk, rst_n, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
`define BSI_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define BSI_ASSERT(name, clk, rst_n, expr)
`define BSI_ASSERT_IMP(name, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/bsi_pkg.sv @@
// ---------------------------------------------------------------------------
// bsi_pkg
// Types and constants of the brush stroke interpolator.
// ---------------------------------------------------------------------------
package bsi_pkg;

    // Event kinds
    localparam logic [2:0] REQ_PRESS   = 3'd0;
    localparam logic [2:0] REQ_RELEASE = 3'd1;
    localparam logic [2:0] REQ_MOVE    = 3'd2;
    localparam logic [2:0] REQ_CANCEL  = 3'd3;
    localparam logic [2:0] REQ_FINISH  = 3'd4;

    localparam int RADIUS_W = 12;
    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 12'd80;

    // Widest internal coordinate carried between front and back
    localparam int CMD_CW = 32;

    typedef struct packed {
        logic [2:0]         req_type;
        logic               is_left_button;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
    } in_item_t;

    typedef struct packed {
        logic               point_valid;
        logic signed [15:0] point_x;
        logic signed [15:0] point_y;
        logic               stroke_start;
        logic               stroke_delete;
        logic               handled;
        logic               last;
    } out_item_t;

    typedef enum logic {
        OP_SINGLE,
        OP_MOVE
    } cmd_op_t;

    // Classified work handed from the front to the back
    typedef struct packed {
        cmd_op_t                  op;
        logic                     point_valid;
        logic                     stroke_start;
        logic                     stroke_delete;
        logic                     handled;
        logic signed [CMD_CW-1:0] from_x;
        logic signed [CMD_CW-1:0] from_y;
        logic signed [CMD_CW:0]   dx;
        logic signed [CMD_CW:0]   dy;
    } cmd_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_SQX,
        B_SQY,
        B_CNT,
        B_DIV,
        B_PT
    } back_state_t;

endpackage

@@ rtl/bsi_front.sv @@
// ---------------------------------------------------------------------------
// bsi_front
// Accepts pointer events, tracks the drawing state and the last point, and
// turns each event into one command for the back end.
// ---------------------------------------------------------------------------
module bsi_front #(
    parameter int COORD_BITS = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  bsi_pkg::in_item_t in_data,
    output logic             push,
    output bsi_pkg::cmd_t    cmd,
    input  logic             full
);
    import bsi_pkg::*;

    localparam int CW = COORD_BITS;
    localparam int DW = COORD_BITS + 1;

    logic                 drawing_reg, drawing_next;
    logic signed [CW-1:0] last_x_reg, last_x_next;
    logic signed [CW-1:0] last_y_reg, last_y_next;
    logic signed [CW-1:0] px, py;
    logic signed [DW-1:0] dx, dy;

    assign in_ready = !full;
    assign push     = in_valid && !full;

    // Take the low coordinate bits as a signed value
    assign px = CW'(in_data.pos_x);
    assign py = CW'(in_data.pos_y);
    assign dx = DW'(px) - DW'(last_x_reg);
    assign dy = DW'(py) - DW'(last_y_reg);

    // Classify the event
    always_comb
    begin
        drawing_next      = drawing_reg;
        last_x_next       = last_x_reg;
        last_y_next       = last_y_reg;
        cmd               = '0;
        cmd.op            = OP_SINGLE;
        unique case (in_data.req_type) inside
            REQ_PRESS:
            begin
                if (in_data.is_left_button)
                begin
                    drawing_next     = 1'b1;
                    last_x_next      = px;
                    last_y_next      = py;
                    cmd.point_valid  = 1'b1;
                    cmd.stroke_start = 1'b1;
                    cmd.handled      = 1'b1;
                    cmd.from_x       = CMD_CW'(px);
                    cmd.from_y       = CMD_CW'(py);
                end
            end
            REQ_RELEASE:
            begin
                if (in_data.is_left_button)
                begin
                    drawing_next = 1'b0;
                    cmd.handled  = 1'b1;
                end
            end
            REQ_MOVE:
            begin
                if (drawing_reg)
                begin
                    cmd.handled = 1'b1;
                    last_x_next = px;
                    last_y_next = py;
                    if (dx == '0 && dy == '0)
                    begin
                        cmd.point_valid = 1'b1;
                        cmd.from_x      = CMD_CW'(px);
                        cmd.from_y      = CMD_CW'(py);
                    end
                    else
                    begin
                        cmd.op     = OP_MOVE;
                        cmd.from_x = CMD_CW'(last_x_reg);
                        cmd.from_y = CMD_CW'(last_y_reg);
                        cmd.dx     = (CMD_CW+1)'(dx);
                        cmd.dy     = (CMD_CW+1)'(dy);
                    end
                end
            end
            REQ_CANCEL, REQ_FINISH:
            begin
                drawing_next      = 1'b0;
                cmd.handled       = drawing_reg;
                cmd.stroke_delete = drawing_reg && (in_data.req_type == REQ_CANCEL);
            end
            default:
            begin
                cmd.handled = 1'b0;
            end
        endcase
    end

    // Update the stroke state on each accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drawing_reg <= 1'b0;
            last_x_reg  <= '0;
            last_y_reg  <= '0;
        end
        else if (push)
        begin
            drawing_reg <= drawing_next;
            last_x_reg  <= last_x_next;
            last_y_reg  <= last_y_next;
        end
    end

endmodule

@@ rtl/bsi_queue.sv @@
// ---------------------------------------------------------------------------
// bsi_queue
// Two-entry command queue between the front and the back end.
// ---------------------------------------------------------------------------
module bsi_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  bsi_pkg::cmd_t push_data,
    output logic          full,
    input  logic          pop,
    output logic          pop_valid,
    output bsi_pkg::cmd_t pop_data
);
    import bsi_pkg::*;

    cmd_t       mem [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign full      = (count_reg == 2'd2);
    assign pop_valid = (count_reg != 2'd0);
    assign pop_data  = mem[rd_ptr_reg];

    // Store the entry
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

@@ rtl/bsi_back.sv @@
// ---------------------------------------------------------------------------
// bsi_back
// Carries out commands: emits single results, and for a move finds the step
// count, divides the deltas once and walks the stamp points.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"
module bsi_back #(
    parameter int MAX_STEPS  = 64,
    parameter int COORD_BITS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [bsi_pkg::RADIUS_W-1:0]     brush_radius,
    input  logic                             cmd_valid,
    input  bsi_pkg::cmd_t                    cmd,
    output logic                             pop,
    output logic                             out_valid,
    input  logic                             out_ready,
    output bsi_pkg::out_item_t               out_data
);
    import bsi_pkg::*;

    localparam int CW   = COORD_BITS;
    localparam int AW   = COORD_BITS + 1;
    localparam int SW   = $clog2(MAX_STEPS + 1);
    localparam int RW   = SW + 2;
    localparam int SPW  = RADIUS_W + 1;
    localparam int CSW  = SPW + SW;
    localparam int CSQW = 2 * CSW;
    localparam int D2W  = 2 * AW + 1;
    localparam int CMPW = (CSQW > D2W) ? CSQW : D2W;
    localparam int DCW  = $clog2(AW);

    back_state_t          state_reg, state_next;
    logic [AW-1:0]        ax_reg, ax_next, ay_reg, ay_next;
    logic                 negx_reg, negx_next, negy_reg, negy_next;
    logic signed [CW-1:0] fx_reg, fx_next, fy_reg, fy_next;
    logic [D2W-1:0]       d2_reg, d2_next;
    logic [SW-1:0]        s_reg, s_next, i_reg, i_next;
    logic [CSW-1:0]       c_reg, c_next;
    logic [AW-1:0]        numx_reg, numx_next, numy_reg, numy_next;
    logic [SW-1:0]        remx_reg, remx_next, remy_reg, remy_next;
    logic [DCW-1:0]       dcnt_reg, dcnt_next;
    logic [AW-1:0]        qx_reg, qx_next, qy_reg, qy_next;
    logic [RW-1:0]        rx_reg, rx_next, ry_reg, ry_next;
    logic                 out_valid_reg, out_valid_next;
    out_item_t            out_reg, out_next;

    logic signed [AW-1:0] dxw, dyw;
    logic [SPW-1:0]       sp;
    logic [CMPW-1:0]      csq;
    logic                 out_free;
    logic [SW:0]          tx, ty;
    logic                 gex, gey;
    logic [RW-1:0]        two_s, sx, sy;
    logic [AW-1:0]        qnx, qny;
    logic signed [AW:0]   ptx, pty;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign out_free  = !out_valid_reg || out_ready;
    assign dxw       = AW'(cmd.dx);
    assign dyw       = AW'(cmd.dy);
    assign sp        = {brush_radius, 1'b0};
    assign csq       = CMPW'(c_reg) * CMPW'(c_reg);

    // Restoring divider step, one bit per lane
    assign tx  = {remx_reg, numx_reg[AW-1]};
    assign ty  = {remy_reg, numy_reg[AW-1]};
    assign gex = tx >= {1'b0, s_reg};
    assign gey = ty >= {1'b0, s_reg};

    // Running quotient and remainder of (2*a*i + s) / (2*s)
    always_comb
    begin
        two_s = RW'({s_reg, 1'b0});
        sx    = rx_reg + RW'({remx_reg, 1'b0});
        sy    = ry_reg + RW'({remy_reg, 1'b0});
        qnx   = qx_reg + numx_reg;
        qny   = qy_reg + numy_reg;
        if (sx >= two_s)
        begin
            sx  = sx - two_s;
            qnx = qnx + AW'(1);
        end
        if (sy >= two_s)
        begin
            sy  = sy - two_s;
            qny = qny + AW'(1);
        end
        ptx = (AW+1)'(fx_reg) + (negx_reg ? -$signed({1'b0, qnx}) : $signed({1'b0, qnx}));
        pty = (AW+1)'(fy_reg) + (negy_reg ? -$signed({1'b0, qny}) : $signed({1'b0, qny}));
    end

    // Sequence the command
    always_comb
    begin
        state_next     = state_reg;
        ax_next        = ax_reg;
        ay_next        = ay_reg;
        negx_next      = negx_reg;
        negy_next      = negy_reg;
        fx_next        = fx_reg;
        fy_next        = fy_reg;
        d2_next        = d2_reg;
        s_next         = s_reg;
        i_next         = i_reg;
        c_next         = c_reg;
        numx_next      = numx_reg;
        numy_next      = numy_reg;
        remx_next      = remx_reg;
        remy_next      = remy_reg;
        dcnt_next      = dcnt_reg;
        qx_next        = qx_reg;
        qy_next        = qy_reg;
        rx_next        = rx_reg;
        ry_next        = ry_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        pop            = 1'b0;
        unique case (state_reg)
            B_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd.op == OP_SINGLE)
                    begin
                        if (out_free)
                        begin
                            pop                    = 1'b1;
                            out_valid_next         = 1'b1;
                            out_next.point_valid   = cmd.point_valid;
                            out_next.point_x       = 16'(cmd.from_x);
                            out_next.point_y       = 16'(cmd.from_y);
                            out_next.stroke_start  = cmd.stroke_start;
                            out_next.stroke_delete = cmd.stroke_delete;
                            out_next.handled       = cmd.handled;
                            out_next.last          = 1'b1;
                        end
                    end
                    else
                    begin
                        pop        = 1'b1;
                        negx_next  = dxw[AW-1];
                        negy_next  = dyw[AW-1];
                        ax_next    = dxw[AW-1] ? AW'(-dxw) : AW'(dxw);
                        ay_next    = dyw[AW-1] ? AW'(-dyw) : AW'(dyw);
                        fx_next    = CW'(cmd.from_x);
                        fy_next    = CW'(cmd.from_y);
                        state_next = B_SQX;
                    end
                end
            end
            B_SQX:
            begin
                d2_next    = D2W'(ax_reg) * D2W'(ax_reg);
                state_next = B_SQY;
            end
            B_SQY:
            begin
                d2_next    = d2_reg + D2W'(ay_reg) * D2W'(ay_reg);
                s_next     = SW'(1);
                c_next     = CSW'(sp);
                state_next = B_CNT;
            end
            B_CNT:
            begin
                if (s_reg == SW'(MAX_STEPS) || csq >= CMPW'(d2_reg))
                begin
                    numx_next  = ax_reg;
                    numy_next  = ay_reg;
                    remx_next  = '0;
                    remy_next  = '0;
                    dcnt_next  = '0;
                    state_next = B_DIV;
                end
                else
                begin
                    s_next = s_reg + SW'(1);
                    c_next = c_reg + CSW'(sp);
                end
            end
            B_DIV:
            begin
                remx_next = gex ? SW'(tx - {1'b0, s_reg}) : SW'(tx);
                remy_next = gey ? SW'(ty - {1'b0, s_reg}) : SW'(ty);
                numx_next = {numx_reg[AW-2:0], gex};
                numy_next = {numy_reg[AW-2:0], gey};
                dcnt_next = dcnt_reg + DCW'(1);
                if (dcnt_reg == DCW'(AW - 1))
                begin
                    qx_next    = '0;
                    qy_next    = '0;
                    rx_next    = RW'(s_reg);
                    ry_next    = RW'(s_reg);
                    i_next     = SW'(1);
                    state_next = B_PT;
                end
            end
            B_PT:
            begin
                if (out_free)
                begin
                    out_valid_next         = 1'b1;
                    out_next.point_valid   = 1'b1;
                    out_next.point_x       = 16'(ptx);
                    out_next.point_y       = 16'(pty);
                    out_next.stroke_start  = 1'b0;
                    out_next.stroke_delete = 1'b0;
                    out_next.handled       = 1'b1;
                    out_next.last          = (i_reg == s_reg);
                    qx_next                = qnx;
                    qy_next                = qny;
                    rx_next                = sx;
                    ry_next                = sy;
                    i_next                 = i_reg + SW'(1);
                    if (i_reg == s_reg)
                    begin
                        state_next = B_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold datapath registers
    always_ff @(posedge clk)
    begin
        ax_reg   <= ax_next;
        ay_reg   <= ay_next;
        negx_reg <= negx_next;
        negy_reg <= negy_next;
        fx_reg   <= fx_next;
        fy_reg   <= fy_next;
        d2_reg   <= d2_next;
        s_reg    <= s_next;
        i_reg    <= i_next;
        c_reg    <= c_next;
        numx_reg <= numx_next;
        numy_reg <= numy_next;
        remx_reg <= remx_next;
        remy_reg <= remy_next;
        dcnt_reg <= dcnt_next;
        qx_reg   <= qx_next;
        qy_reg   <= qy_next;
        rx_reg   <= rx_next;
        ry_reg   <= ry_next;
        out_reg  <= out_next;
    end

    `BSI_ASSERT_IMP(a_pt_index, clk, rst_n, state_reg == B_PT, i_reg != '0 && i_reg <= s_reg)
    `BSI_ASSERT_IMP(a_pt_rem, clk, rst_n, state_reg == B_PT, remx_reg < s_reg && remy_reg < s_reg)
    `BSI_ASSERT_IMP(a_pt_end, clk, rst_n, state_reg == B_PT && out_free && i_reg == s_reg, ##1 state_reg == B_IDLE && out_valid_reg && out_reg.last)

endmodule

@@ rtl/brush_stroke_interpolator.sv @@
// ---------------------------------------------------------------------------
// brush_stroke_interpolator
// Pointer events in, brush stamp points out.
// ---------------------------------------------------------------------------
// Every event gives one result, except a move while drawing to a new
// position, which gives s = min(MAX_STEPS, ceil(length / (2 * brush_radius)))
// points. Such a move first finds the step count (one square compare per
// candidate), then runs the bit-serial division of both deltas, then gives
// one point per cycle while the output is taken. A two-entry queue lets the
// next events be accepted while a move is still being walked.
module brush_stroke_interpolator #(
    parameter int MAX_STEPS  = 64,
    parameter int COORD_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bsi_pkg::RADIUS_W-1:0]  cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  bsi_pkg::in_item_t             in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output bsi_pkg::out_item_t            out_data
);
    import bsi_pkg::*;

    logic [RADIUS_W-1:0] radius_reg;
    logic                push, full, pop, cmd_valid;
    cmd_t                push_cmd, cmd;

    assign cfg_ready = 1'b1;

    // Hold the brush radius
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_RESET;
        end
        else if (cfg_valid)
        begin
            radius_reg <= cfg_data;
        end
    end

    bsi_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .push     (push),
        .cmd      (push_cmd),
        .full     (full)
    );

    bsi_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_cmd),
        .full      (full),
        .pop       (pop),
        .pop_valid (cmd_valid),
        .pop_data  (cmd)
    );

    bsi_back #(
        .MAX_STEPS  (MAX_STEPS),
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .brush_radius (radius_reg),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_data     (out_data)
    );

endmodule
